[design/spr_pkg.sv]
`default_nettype none

package spr_pkg;

    // Field widths.
    localparam int unsigned POS_W   = 23;
    localparam int unsigned VALUE_W = 25;
    localparam int unsigned SPEED_W = 23;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned CFG_IDX_W = 2;

    // Position scale: 100 percent in units of 1/65536 percent.
    localparam logic [POS_W-1:0]   POS_FULL  = 23'd6553600;
    // Slowest accepted speed, one percent per second.
    localparam logic [SPEED_W-1:0] SPEED_MIN = 23'd66;

    // Division by 100 as a reciprocal multiply: q = (x * RECIP_100) >> RECIP_SHIFT.
    // Exact for every x below 2^19.
    localparam int unsigned        RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_100   = 20'd671089;
    localparam int unsigned        RECIP_SHIFT = 26;

    // Parameter defaults.
    localparam int unsigned DEF_STEP_PERIOD_MS = 10;
    localparam int unsigned DEF_PULSE_BITS     = 12;

    // Register reset values.
    localparam logic [SPEED_W-1:0] SLEW_RESET      = 23'd655;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 12'd360;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 12'd2500;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX  = 2'd2;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_MOVE_ABS = 2'd1,
        KIND_MOVE_REL = 2'd2,
        KIND_STOP     = 2'd3
    } kind_t;

    // Clip a signed goal to the 0..100 percent range.
    function automatic logic [POS_W-1:0] clip_goal(input logic signed [VALUE_W:0] g);
        logic [POS_W-1:0] r;
        if (g < 0)
            r = '0;
        else if (g > $signed({{(VALUE_W+1-POS_W){1'b0}}, POS_FULL}))
            r = POS_FULL;
        else
            r = g[POS_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[design/servo_position_ramp_top.sv]
`default_nettype none

// Slew-rate limited servo position ramp. Each transfer on the input stream is a
// millisecond tick (tuser = 0) or a move command: absolute (1), relative (2) or
// stop (3), with the goal or offset in tdata. Every STEP_PERIOD_MS ticks the
// position steps toward the goal by slew_speed * STEP_PERIOD_MS, the drive is
// switched on first and off once the goal is reached, and the pulse width
// pulse_min + (pulse_max - pulse_min) * position / 100 percent is held until the
// next step. Every input item gives exactly one result item. The block takes
// one item per clock cycle while the result stream does not stall, and each
// result passes four registers: the input register, the state update, the
// range times position multiply, and the divide-by-100 reciprocal multiply
// into the result register.
// The user writes registers through the configuration channel only while no items
// are in flight; the block does not enforce it. slew_speed writes below 66 are dropped.
module servo_position_ramp_top
    import spr_pkg::*;
#(
    parameter int unsigned STEP_PERIOD_MS = DEF_STEP_PERIOD_MS,
    parameter int unsigned PULSE_BITS     = DEF_PULSE_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SPEED_W-1:0]   cfg_data,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,  // [24:0] value
    input  wire logic [1:0]           s_tuser,  // [1:0] kind
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata   // [11:0] pulse_width, [12] driving,
                                                // [35:13] position_now,
                                                // [58:36] position_goal, [63:59] zero
);

    localparam int unsigned CNT_W  = $clog2(STEP_PERIOD_MS + 1);
    localparam int unsigned MV_W   = SPEED_W + CNT_W;
    localparam int unsigned PROD_W = PULSE_W + POS_W;
    localparam int unsigned QX_W   = PROD_W - 16;
    localparam int unsigned RP_W   = QX_W + RECIP_W;
    localparam logic [CNT_W-1:0] PERIOD = CNT_W'(STEP_PERIOD_MS);
    localparam logic [16:0] PULSE_LIM = 17'((64'd1 << PULSE_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_CLEAR,
        ACT_LOAD
    } pulse_act_t;

    // Configuration registers.
    logic [SPEED_W-1:0] slew_reg;
    logic [PULSE_W-1:0] pmin_reg;
    logic [PULSE_W-1:0] pmax_reg;

    // Ramp state.
    logic [POS_W-1:0]   pos_reg,  pos_next;
    logic [POS_W-1:0]   tgt_reg,  tgt_next;
    logic               drv_reg,  drv_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    pulse_act_t         act_next;

    // Pipeline stages.
    logic               s1_v_reg;
    kind_t              s1_kind_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    logic               s2_v_reg;
    logic [POS_W-1:0]   s2_pos_reg;
    logic [POS_W-1:0]   s2_tgt_reg;
    logic               s2_drv_reg;
    pulse_act_t         s2_act_reg;

    logic               s3_v_reg;
    logic [QX_W-1:0]    s3_qx_reg;
    logic [POS_W-1:0]   s3_pos_reg;
    logic [POS_W-1:0]   s3_tgt_reg;
    logic               s3_drv_reg;
    pulse_act_t         s3_act_reg;

    logic               out_v_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic               out_drv_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [POS_W-1:0]   out_tgt_reg;

    logic en_out, en3, en2, en1;

    // Stage enables: a stage moves on when it is empty or the next one moves.
    assign en_out   = !out_v_reg || m_tready;
    assign en3      = !s3_v_reg  || en_out;
    assign en2      = !s2_v_reg  || en3;
    assign en1      = !s1_v_reg  || en2;
    assign s_tready = en1;
    assign cfg_ready = 1'b1;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_reg <= SLEW_RESET;
            pmin_reg <= PULSE_MIN_RESET;
            pmax_reg <= PULSE_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLEW_SPEED:
                begin
                    if (cfg_data >= SPEED_MIN)
                        slew_reg <= cfg_data;
                end
                CFG_PULSE_MIN: pmin_reg <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX: pmax_reg <= cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register; the kind is reset so the state update always sees a known code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s1_kind_reg <= KIND_TICK;
        end
        else if (en1)
        begin
            s1_v_reg <= s_tvalid;
            if (s_tvalid)
                s1_kind_reg <= kind_t'(s_tuser);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            s1_value_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    // State update for the item in the input register.
    logic [CNT_W-1:0] cnt_inc;
    logic [MV_W-1:0]  mv;
    logic             up;
    logic [POS_W-1:0] gap;
    logic [POS_W-1:0] moved;

    always_comb
    begin
        cnt_inc = cnt_reg + 1'b1;
        mv      = MV_W'(slew_reg) * MV_W'(STEP_PERIOD_MS);
        up      = tgt_reg > pos_reg;
        gap     = up ? (tgt_reg - pos_reg) : (pos_reg - tgt_reg);
        if (mv >= MV_W'(gap))
            moved = tgt_reg;
        else if (up)
            moved = pos_reg + mv[POS_W-1:0];
        else
            moved = pos_reg - mv[POS_W-1:0];

        pos_next = pos_reg;
        tgt_next = tgt_reg;
        drv_next = drv_reg;
        cnt_next = cnt_reg;
        act_next = ACT_HOLD;

        unique case (s1_kind_reg)
            KIND_TICK:
            begin
                if (cnt_inc >= PERIOD)
                begin
                    cnt_next = '0;
                    if (pos_reg == tgt_reg)
                    begin
                        drv_next = 1'b0;
                        act_next = ACT_CLEAR;
                    end
                    else if (!drv_reg)
                    begin
                        drv_next = 1'b1;
                        act_next = ACT_LOAD;
                    end
                    else
                    begin
                        pos_next = moved;
                        act_next = ACT_LOAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            KIND_MOVE_ABS:
                tgt_next = clip_goal({s1_value_reg[VALUE_W-1], s1_value_reg});
            KIND_MOVE_REL:
                tgt_next = clip_goal($signed({{(VALUE_W+1-POS_W){1'b0}}, tgt_reg})
                                     + $signed({s1_value_reg[VALUE_W-1], s1_value_reg}));
            KIND_STOP:
                tgt_next = pos_reg;
        endcase
    end

    // State registers and the state stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            tgt_reg  <= '0;
            drv_reg  <= 1'b0;
            cnt_reg  <= '0;
            s2_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_v_reg <= s1_v_reg;
            if (s1_v_reg)
            begin
                pos_reg <= pos_next;
                tgt_reg <= tgt_next;
                drv_reg <= drv_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_v_reg)
        begin
            s2_pos_reg <= pos_next;
            s2_tgt_reg <= tgt_next;
            s2_drv_reg <= drv_next;
            s2_act_reg <= act_next;
        end
    end

    // Range times position, divided by 65536.
    logic [PULSE_W-1:0] prange;
    logic [PROD_W-1:0]  prod;

    assign prange = (pmax_reg >= pmin_reg) ? (pmax_reg - pmin_reg) : '0;
    assign prod   = PROD_W'(prange) * PROD_W'(s2_pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en3)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_v_reg)
        begin
            s3_qx_reg  <= prod[PROD_W-1:16];
            s3_pos_reg <= s2_pos_reg;
            s3_tgt_reg <= s2_tgt_reg;
            s3_drv_reg <= s2_drv_reg;
            s3_act_reg <= s2_act_reg;
        end
    end

    // Divide by 100, add the minimum and saturate.
    logic [RP_W-1:0]    recip_prod;
    logic [16:0]        pulse_sum;
    logic [PULSE_W-1:0] pulse_sat;

    always_comb
    begin
        recip_prod = RP_W'(s3_qx_reg) * RP_W'(RECIP_100);
        pulse_sum  = 17'(pmin_reg) + 17'(recip_prod[RP_W-1:RECIP_SHIFT]);
        if (pulse_sum > PULSE_LIM)
            pulse_sat = PULSE_LIM[PULSE_W-1:0];
        else
            pulse_sat = pulse_sum[PULSE_W-1:0];
    end

    // Result register; the pulse width is held between steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            pulse_reg <= '0;
        end
        else if (en_out)
        begin
            out_v_reg <= s3_v_reg;
            if (s3_v_reg)
            begin
                unique case (s3_act_reg)
                    ACT_CLEAR: pulse_reg <= '0;
                    ACT_LOAD:  pulse_reg <= pulse_sat;
                    default:   pulse_reg <= pulse_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s3_v_reg)
        begin
            out_drv_reg <= s3_drv_reg;
            out_pos_reg <= s3_pos_reg;
            out_tgt_reg <= s3_tgt_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, out_tgt_reg, out_pos_reg, out_drv_reg, pulse_reg};

    // The goal never leaves the 0..100 percent range.
    a_goal_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tgt_reg <= POS_FULL)
        else $error("goal position out of range");

    // The tick counter always wraps before reaching the step period.
    a_cnt_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < PERIOD)
        else $error("tick counter reached the step period");

    // A result with the drive off carries no pulse.
    a_off_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_drv_reg) |-> (pulse_reg == '0))
        else $error("pulse width nonzero while drive is off");

    // The position only changes while the drive is on.
    a_move_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> $past(drv_reg))
        else $error("position moved with the drive off");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import spr_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned DRAIN_PAUSE     = 8;
    localparam int unsigned LONG_HOLD       = 200;
    localparam int unsigned ITEMS_PER_PHASE = 90;
    localparam int unsigned DIRECTED_COUNT  = 20;
    localparam longint unsigned PULSE_CEIL  = (64'd1 << DEF_PULSE_BITS) - 1;
    // No register lives at this index; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One result: what the servo drive shows after an item.
    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               driving;
        logic [POS_W-1:0]   position_now;
        logic [POS_W-1:0]   position_goal;
    } servo_status_t;

    // One row of the directed stimulus; a typed-in result is used when fixed is set.
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               fixed;
        servo_status_t      want;
    } servo_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPEED_W-1:0]   cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;  // [24:0] value
    logic [1:0]           s_tuser = '0;  // [1:0] kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;       // [11:0] pulse_width, [12] driving,
                                         // [35:13] position_now, [58:36] position_goal

    // Shadow of the block: registers and servo state.
    logic [SPEED_W-1:0] slew_rate;
    logic [PULSE_W-1:0] pulse_floor;
    logic [PULSE_W-1:0] pulse_ceiling;
    logic [POS_W-1:0]   servo_pos;
    logic [POS_W-1:0]   servo_goal;
    logic               servo_drive;
    logic [9:0]         tick_count;
    logic [PULSE_W-1:0] servo_pulse;

    servo_status_t pending_status[$];
    servo_row_t    directed_rows [DIRECTED_COUNT];
    int unsigned   fail_count = 0;
    int unsigned   cycle_count = 0;
    logic          feed_gaps = 1'b0;
    logic          stall_results = 1'b0;
    logic          hold_results = 1'b0;

    servo_position_ramp_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Pulse width for a position, saturated to the pulse field.
    function automatic logic [PULSE_W-1:0] pulse_at(logic [POS_W-1:0] pos);
        longint unsigned span;
        longint unsigned width;
        span  = (pulse_ceiling >= pulse_floor) ? longint'(pulse_ceiling - pulse_floor) : 0;
        width = longint'(pulse_floor) + (span * longint'(pos)) / POS_FULL;
        if (width > PULSE_CEIL)
            width = PULSE_CEIL;
        return width[PULSE_W-1:0];
    endfunction

    // Limit a signed goal to 0..100 percent.
    function automatic logic [POS_W-1:0] goal_in_span(longint signed aim);
        if (aim < 0)
            return '0;
        if (aim > longint'(POS_FULL))
            return POS_FULL;
        return aim[POS_W-1:0];
    endfunction

    // Apply one item to the shadow state and return the status it leaves.
    function automatic servo_status_t advance_servo(kind_t kind, logic [VALUE_W-1:0] value);
        longint signed   offset;
        longint unsigned stride;
        longint unsigned gap;
        offset = $signed(value);
        case (kind)
            KIND_TICK:
            begin
                tick_count = tick_count + 10'd1;
                if (tick_count >= DEF_STEP_PERIOD_MS)
                begin
                    tick_count = '0;
                    // Step period: stop at the goal, else power up, else slew.
                    if (servo_pos == servo_goal)
                    begin
                        servo_drive = 1'b0;
                        servo_pulse = '0;
                    end
                    else if (!servo_drive)
                    begin
                        servo_pulse = pulse_at(servo_pos);
                        servo_drive = 1'b1;
                    end
                    else
                    begin
                        stride = longint'(slew_rate) * DEF_STEP_PERIOD_MS;
                        if (servo_goal > servo_pos)
                        begin
                            gap = longint'(servo_goal - servo_pos);
                            servo_pos = (stride >= gap) ? servo_goal
                                        : POS_W'(longint'(servo_pos) + stride);
                        end
                        else
                        begin
                            gap = longint'(servo_pos - servo_goal);
                            servo_pos = (stride >= gap) ? servo_goal
                                        : POS_W'(longint'(servo_pos) - stride);
                        end
                        servo_pulse = pulse_at(servo_pos);
                    end
                end
            end
            KIND_MOVE_ABS: servo_goal = goal_in_span(offset);
            KIND_MOVE_REL: servo_goal = goal_in_span(longint'(servo_goal) + offset);
            default:       servo_goal = servo_pos;
        endcase
        return '{pulse_width: servo_pulse, driving: servo_drive,
                 position_now: servo_pos, position_goal: servo_goal};
    endfunction

    // Register write transfer; the caller lowers cfg_valid after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [SPEED_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_SLEW_SPEED:
                if (data >= SPEED_MIN)
                    slew_rate = data;
            CFG_PULSE_MIN: pulse_floor   = data[PULSE_W-1:0];
            CFG_PULSE_MAX: pulse_ceiling = data[PULSE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Input transfer, with an optional idle burst ahead of it.
    task automatic send_item(kind_t kind, logic [VALUE_W-1:0] value, logic fixed,
                             servo_status_t want);
        servo_status_t predicted;
        if (feed_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_servo(kind, value);
        pending_status.push_back(fixed ? want : predicted);
        @(negedge clk);
    endtask

    // Wait until every result is back, then let the pipeline settle.
    task automatic drain_results();
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE)
            @(negedge clk);
    endtask

    // Random items, mostly ticks, with goals often near the present position
    // so that moves finish and the drive switches off again.
    task automatic run_phase(int unsigned count);
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        int unsigned        pick;
        int                 aim;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick  = $urandom_range(0, 99);
            value = VALUE_W'($urandom());
            aim   = int'(servo_pos) + int'($urandom_range(0, 40000)) - 20000;
            if (pick < 78)
                kind = KIND_TICK;
            else if (pick < 87)
            begin
                kind = KIND_MOVE_ABS;
                if ($urandom_range(0, 2) != 0)
                    value = VALUE_W'(aim);
            end
            else if (pick < 95)
            begin
                kind = KIND_MOVE_REL;
                if ($urandom_range(0, 3) != 0)
                    value = VALUE_W'($urandom_range(0, 60000)) - VALUE_W'(30000);
            end
            else
                kind = KIND_STOP;
            send_item(kind, value, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // Result side: short random stalls, or one long hold-off when asked.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
                hold_results = 1'b0;
            end
            else if (stall_results && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 4))
                    @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expected status.
    always @(posedge clk)
    begin
        servo_status_t want;
        servo_status_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("result transfer with no status expected");
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                got  = '{pulse_width: m_tdata[11:0], driving: m_tdata[12],
                         position_now: m_tdata[35:13], position_goal: m_tdata[58:36]};
                if (got.pulse_width !== want.pulse_width)
                begin
                    $error("pulse_width: expected %0d, actual %0d",
                           want.pulse_width, got.pulse_width);
                    fail_count++;
                end
                if (got.driving !== want.driving)
                begin
                    $error("driving: expected %0d, actual %0d", want.driving, got.driving);
                    fail_count++;
                end
                if (got.position_now !== want.position_now)
                begin
                    $error("position_now: expected %0d, actual %0d",
                           want.position_now, got.position_now);
                    fail_count++;
                end
                if (got.position_goal !== want.position_goal)
                begin
                    $error("position_goal: expected %0d, actual %0d",
                           want.position_goal, got.position_goal);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        // Out-of-range goals, the most negative and positive values, and stop
        // at rest; then one full period that powers the drive up at zero, a relative move and a stop.
        directed_rows = '{
            '{KIND_TICK,     25'h0000000, 1'b1, '{12'd0, 1'b0, 23'd0, 23'd0}},
            '{KIND_MOVE_ABS, 25'h0FFFFFF, 1'b1, '{12'd0, 1'b0, 23'd0, POS_FULL}},
            '{KIND_MOVE_ABS, 25'h1000000, 1'b1, '{12'd0, 1'b0, 23'd0, 23'd0}},
            '{KIND_MOVE_REL, 25'h0FFFFFF, 1'b1, '{12'd0, 1'b0, 23'd0, POS_FULL}},
            '{KIND_MOVE_REL, 25'h1000000, 1'b1, '{12'd0, 1'b0, 23'd0, 23'd0}},
            '{KIND_MOVE_ABS, 25'h1FFFFFF, 1'b1, '{12'd0, 1'b0, 23'd0, 23'd0}},
            '{KIND_MOVE_ABS, 25'd6553601, 1'b1, '{12'd0, 1'b0, 23'd0, POS_FULL}},
            '{KIND_STOP,     25'h1555555, 1'b1, '{12'd0, 1'b0, 23'd0, 23'd0}},
            '{KIND_MOVE_ABS, 25'd6553600, 1'b1, '{12'd0, 1'b0, 23'd0, POS_FULL}},
            '{KIND_TICK,     25'h1FFFFFF, 1'b0, '0},
            '{KIND_TICK,     25'h0AAAAAA, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b0, '0},
            '{KIND_TICK,     25'h0000000, 1'b1, '{PULSE_MIN_RESET, 1'b1, 23'd0, POS_FULL}},
            '{KIND_MOVE_REL, -25'sd6553000, 1'b0, '0},
            '{KIND_STOP,     25'h0000000, 1'b0, '0}
        };
        slew_rate     = SLEW_RESET;
        pulse_floor   = PULSE_MIN_RESET;
        pulse_ceiling = PULSE_MAX_RESET;
        servo_pos     = '0;
        servo_goal    = '0;
        servo_drive   = 1'b0;
        tick_count    = '0;
        servo_pulse   = '0;

        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        // Writes that must be dropped: unused index and a too slow speed.
        write_reg(CFG_UNUSED, 23'h7FFFFF);
        write_reg(CFG_SLEW_SPEED, 23'd65);
        cfg_valid <= 1'b0;

        feed_gaps     = 1'b1;
        stall_results = 1'b1;
        for (int unsigned r = 0; r < DIRECTED_COUNT; r++)
            send_item(directed_rows[r].kind, directed_rows[r].value,
                      directed_rows[r].fixed, directed_rows[r].want);
        s_tvalid <= 1'b0;

        // Slowest speed, full pulse range; upper data bits must be ignored.
        drain_results();
        write_reg(CFG_SLEW_SPEED, SPEED_MIN);
        write_reg(CFG_PULSE_MIN, {11'($urandom()), 12'd0});
        write_reg(CFG_PULSE_MAX, {11'($urandom()), 12'hFFF});
        cfg_valid <= 1'b0;
        run_phase(ITEMS_PER_PHASE);

        // Fastest speed and inverted pulse limits, with a long result hold-off.
        drain_results();
        write_reg(CFG_SLEW_SPEED, 23'h7FFFFF);
        write_reg(CFG_PULSE_MIN, 23'h000FFF);
        write_reg(CFG_PULSE_MAX, 23'h7FF000);
        cfg_valid <= 1'b0;
        hold_results = 1'b1;
        run_phase(ITEMS_PER_PHASE);

        // Random settings, limits possibly inverted.
        drain_results();
        write_reg(CFG_SLEW_SPEED, SPEED_W'($urandom_range(66, 200000)));
        write_reg(CFG_PULSE_MIN, SPEED_W'($urandom()));
        write_reg(CFG_PULSE_MAX, SPEED_W'($urandom()));
        cfg_valid <= 1'b0;
        run_phase(ITEMS_PER_PHASE);

        // Top pulse limits; the speed write below the floor keeps the old speed.
        drain_results();
        write_reg(CFG_SLEW_SPEED, 23'd65);
        write_reg(CFG_PULSE_MIN, 23'h000FFF);
        write_reg(CFG_PULSE_MAX, 23'h000FFF);
        write_reg(CFG_UNUSED, 23'h000000);
        cfg_valid <= 1'b0;
        run_phase(ITEMS_PER_PHASE);

        // Reset settings at full rate with no idling on either side.
        drain_results();
        write_reg(CFG_SLEW_SPEED, SLEW_RESET);
        write_reg(CFG_PULSE_MIN, PULSE_MIN_RESET);
        write_reg(CFG_PULSE_MAX, PULSE_MAX_RESET);
        cfg_valid <= 1'b0;
        feed_gaps     = 1'b0;
        stall_results = 1'b0;
        run_phase(ITEMS_PER_PHASE);

        drain_results();
        repeat (DRAIN_PAUSE)
            @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
